// File: sv/lrcr_pkg.sv
// Package for the column-run line rasterizer: field widths, opcodes,
// walk modes and sequencer states. No dependencies.
`timescale 1ns / 1ps

package lrcr_pkg;

   localparam int COL_W = 7;    // column coordinate width
   localparam int ROW_W = 8;    // row coordinate width
   localparam int ERR_W = 11;   // signed error term width
   localparam int DY2_W = 9;    // twice the row span

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_VERT  = 2'd1,
      MODE_SLOPE = 2'd2
   } walk_mode_type;

   typedef enum logic {
      ST_READY = 1'b0,
      ST_WALK  = 1'b1
   } seq_state_type;

endpackage

// File: sv/line_rasterizer_column_runs_top.sv
// Top level of the column-run line rasterizer: request, response and CSR channels,
// walk state and the shared error compare/subtract unit. Depends on lrcr_pkg.
`timescale 1ns / 1ps

// Usage
//   req_*  : one transfer per command. req_opcode OP_LOAD takes a new line
//            (start/end endpoints, swapped so the walk runs left to right) and
//            gives no response. OP_STEP asks for the next column run.
//   rsp_*  : one transfer per OP_STEP: column, first and last row of the run,
//            pixel value, empty flag and last flag.
//   csr_*  : write of invert_ink; always ready, takes effect on the transfer.
//            Write it only while no step is in flight.
// Timing
//   A load is taken as one transfer. A step holds the request port until its
//   result is registered, while the error term goes through one shared
//   compare/subtract unit, one row step per cycle, for k row steps, where k
//   is the number of rows the line moves in that column. Vertical lines and
//   idle steps have k = 0. The result lands in the response register when
//   the step finishes; steep lines (one column, many rows) take the longest.
// Reset
//   Synchronous, active high: walk idle, invert_ink 0, no response pending.
// Stall
//   The response register holds one result. A load may be taken while it
//   waits; a step finishing while it is still full waits in the walk state.

module line_rasterizer_column_runs_top (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_opcode,
   input  logic [lrcr_pkg::COL_W-1:0] req_start_x,
   input  logic [lrcr_pkg::ROW_W-1:0] req_start_y,
   input  logic [lrcr_pkg::COL_W-1:0] req_end_x,
   input  logic [lrcr_pkg::ROW_W-1:0] req_end_y,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [lrcr_pkg::COL_W-1:0] rsp_column_x,
   output logic [lrcr_pkg::ROW_W-1:0] rsp_run_first_y,
   output logic [lrcr_pkg::ROW_W-1:0] rsp_run_last_y,
   output logic                       rsp_pixel_value,
   output logic                       rsp_empty_res,
   output logic                       rsp_last,
   // CSR write channel
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic                       csr_invert_ink
);

   // sequencer
   lrcr_pkg::seq_state_type state_ff, state_in;

   // walk state
   lrcr_pkg::walk_mode_type mode_ff, mode_in;
   logic [lrcr_pkg::COL_W-1:0]        cur_col_ff, cur_col_in;
   logic [lrcr_pkg::COL_W-1:0]        stop_col_ff, stop_col_in;
   logic [lrcr_pkg::ROW_W-1:0]        cur_row_ff, cur_row_in;
   logic [lrcr_pkg::ROW_W-1:0]        vstop_row_ff, vstop_row_in;
   logic [lrcr_pkg::ROW_W-1:0]        first_row_ff, first_row_in;
   logic signed [lrcr_pkg::ERR_W-1:0] err_ff, err_in;
   logic [lrcr_pkg::COL_W-1:0]        span_ff, span_in;
   logic [lrcr_pkg::DY2_W-1:0]        dy2_ff, dy2_in;
   logic                              down_ff, down_in;
   logic                              ink_ff, ink_in;

   // response register
   logic                       out_valid_ff, out_valid_in;
   logic [lrcr_pkg::COL_W-1:0] out_col_ff, out_col_in;
   logic [lrcr_pkg::ROW_W-1:0] out_first_ff, out_first_in;
   logic [lrcr_pkg::ROW_W-1:0] out_last_y_ff, out_last_y_in;
   logic                       out_pix_ff, out_pix_in;
   logic                       out_empty_ff, out_empty_in;
   logic                       out_last_ff, out_last_in;

   // control
   logic req_xfer;
   logic step_xfer;
   logic load_xfer;
   logic out_free;
   logic walk_more;     // slope walk still has a row step to take
   logic finish_go;     // result goes into the response register this cycle

   // shared error unit
   logic signed [lrcr_pkg::ERR_W-1:0] span_ext;
   logic signed [lrcr_pkg::ERR_W-1:0] span2_ext;
   logic signed [lrcr_pkg::ERR_W-1:0] err_sub;

   // load-time endpoint ordering
   logic                       swap;
   logic [lrcr_pkg::COL_W-1:0] ld_x0, ld_x1;
   logic [lrcr_pkg::ROW_W-1:0] ld_y0, ld_y1;
   logic                       ld_down;
   logic [lrcr_pkg::ROW_W-1:0] ld_dy;
   logic [lrcr_pkg::COL_W:0]   next_col;

   assign csr_ready = 1'b1;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;
   assign step_xfer = req_xfer && (req_opcode == lrcr_pkg::OP_STEP);
   assign load_xfer = req_xfer && (req_opcode == lrcr_pkg::OP_LOAD);

   assign span_ext  = lrcr_pkg::ERR_W'(span_ff);
   assign span2_ext = lrcr_pkg::ERR_W'({span_ff, 1'b0});
   assign err_sub   = err_ff - span2_ext;
   assign walk_more = (mode_ff == lrcr_pkg::MODE_SLOPE) && (err_ff >= span_ext);
   assign next_col  = {1'b0, cur_col_ff} + 1'b1;

   assign swap    = req_start_x > req_end_x;
   assign ld_x0   = swap ? req_end_x   : req_start_x;
   assign ld_x1   = swap ? req_start_x : req_end_x;
   assign ld_y0   = swap ? req_end_y   : req_start_y;
   assign ld_y1   = swap ? req_start_y : req_end_y;
   assign ld_down = ld_y1 > ld_y0;
   assign ld_dy   = ld_down ? (ld_y1 - ld_y0) : (ld_y0 - ld_y1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lrcr_pkg::ST_READY: begin
            if (step_xfer) state_in = lrcr_pkg::ST_WALK;
         end
         lrcr_pkg::ST_WALK: begin
            if (!walk_more && out_free) state_in = lrcr_pkg::ST_READY;
         end
         default: state_in = lrcr_pkg::ST_READY;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      finish_go = 1'b0;
      case (state_ff)
         lrcr_pkg::ST_READY: req_ready = 1'b1;
         lrcr_pkg::ST_WALK:  finish_go = !walk_more && out_free;
         default: begin
            req_ready = 1'b0;
            finish_go = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      mode_in      = mode_ff;
      cur_col_in   = cur_col_ff;
      stop_col_in  = stop_col_ff;
      cur_row_in   = cur_row_ff;
      vstop_row_in = vstop_row_ff;
      first_row_in = first_row_ff;
      err_in       = err_ff;
      span_in      = span_ff;
      dy2_in       = dy2_ff;
      down_in      = down_ff;
      ink_in       = (csr_valid && csr_ready) ? csr_invert_ink : ink_ff;

      out_valid_in  = out_valid_ff && !rsp_ready;
      out_col_in    = out_col_ff;
      out_first_in  = out_first_ff;
      out_last_y_in = out_last_y_ff;
      out_pix_in    = out_pix_ff;
      out_empty_in  = out_empty_ff;
      out_last_in   = out_last_ff;

      if (load_xfer) begin
         cur_col_in   = ld_x0;
         stop_col_in  = ld_x1;
         cur_row_in   = ld_y0;
         vstop_row_in = ld_y1;
         err_in       = '0;
         span_in      = ld_x1 - ld_x0;
         down_in      = ld_down;
         dy2_in       = {ld_dy, 1'b0};
         mode_in      = (ld_x0 == ld_x1) ? lrcr_pkg::MODE_VERT : lrcr_pkg::MODE_SLOPE;
      end

      // step entry: fold in this column's row span
      if (step_xfer) begin
         first_row_in = cur_row_ff;
         if (mode_ff == lrcr_pkg::MODE_SLOPE)
            err_in = err_ff + lrcr_pkg::ERR_W'(dy2_ff);
      end

      // one row step per cycle through the shared unit
      if (state_ff == lrcr_pkg::ST_WALK && walk_more) begin
         err_in     = err_sub;
         cur_row_in = down_ff ? (cur_row_ff + 1'b1) : (cur_row_ff - 1'b1);
      end

      if (finish_go) begin
         out_valid_in = 1'b1;
         case (mode_ff)
            lrcr_pkg::MODE_SLOPE: begin
               out_col_in    = cur_col_ff;
               out_first_in  = first_row_ff;
               out_last_y_in = cur_row_ff;
               out_pix_in    = !ink_ff;
               out_empty_in  = 1'b0;
               out_last_in   = next_col >= {1'b0, stop_col_ff};
               cur_col_in    = next_col[lrcr_pkg::COL_W-1:0];
               if (next_col >= {1'b0, stop_col_ff}) mode_in = lrcr_pkg::MODE_IDLE;
            end
            lrcr_pkg::MODE_VERT: begin
               mode_in = lrcr_pkg::MODE_IDLE;
               out_last_in = 1'b1;
               if (vstop_row_ff > cur_row_ff) begin
                  out_col_in    = cur_col_ff;
                  out_first_in  = cur_row_ff;
                  out_last_y_in = vstop_row_ff - 1'b1;
                  out_pix_in    = 1'b1;
                  out_empty_in  = 1'b0;
               end else begin
                  out_col_in    = '0;
                  out_first_in  = '0;
                  out_last_y_in = '0;
                  out_pix_in    = 1'b0;
                  out_empty_in  = 1'b1;
               end
            end
            default: begin
               // step with no line loaded, or past the end of the line
               mode_in       = lrcr_pkg::MODE_IDLE;
               out_col_in    = '0;
               out_first_in  = '0;
               out_last_y_in = '0;
               out_pix_in    = 1'b0;
               out_empty_in  = 1'b1;
               out_last_in   = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lrcr_pkg::ST_READY;
         mode_ff      <= lrcr_pkg::MODE_IDLE;
         cur_col_ff   <= '0;
         stop_col_ff  <= '0;
         cur_row_ff   <= '0;
         vstop_row_ff <= '0;
         err_ff       <= '0;
         span_ff      <= '0;
         dy2_ff       <= '0;
         down_ff      <= 1'b0;
         ink_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         cur_col_ff   <= cur_col_in;
         stop_col_ff  <= stop_col_in;
         cur_row_ff   <= cur_row_in;
         vstop_row_ff <= vstop_row_in;
         err_ff       <= err_in;
         span_ff      <= span_in;
         dy2_ff       <= dy2_in;
         down_ff      <= down_in;
         ink_ff       <= ink_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      first_row_ff  <= first_row_in;
      out_col_ff    <= out_col_in;
      out_first_ff  <= out_first_in;
      out_last_y_ff <= out_last_y_in;
      out_pix_ff    <= out_pix_in;
      out_empty_ff  <= out_empty_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_column_x    = out_col_ff;
   assign rsp_run_first_y = out_first_ff;
   assign rsp_run_last_y  = out_last_y_ff;
   assign rsp_pixel_value = out_pix_ff;
   assign rsp_empty_res   = out_empty_ff;
   assign rsp_last        = out_last_ff;

   // a finishing step never overwrites a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      finish_go |-> (!out_valid_ff || rsp_ready))
      else $error("result register overwritten");

   // each row step shrinks the error term
   a_err_falls: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lrcr_pkg::ST_WALK && walk_more) |=> (err_ff < $past(err_ff)))
      else $error("error term did not fall");

   // between steps of a sloped line the error stays in [-span, span)
   a_err_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lrcr_pkg::ST_READY && mode_ff == lrcr_pkg::MODE_SLOPE)
      |-> (err_ff < span_ext && err_ff >= -span_ext))
      else $error("error term out of range");

   // empty results carry zero payload and close the line
   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_empty_ff) |-> (out_last_ff && !out_pix_ff && out_col_ff == '0))
      else $error("empty result with payload");

endmodule

// File: tb/sv/testbench.sv
// Testbench for line_rasterizer_column_runs_top: directed and random line walks
// checked against an in-bench column-run predictor, with random stalls on both sides.
// Depends on lrcr_pkg and the rasterizer RTL.
`timescale 1ns / 1ps

module testbench;

   localparam int MAX_X = (1 << lrcr_pkg::COL_W) - 1;
   localparam int MAX_Y = (1 << lrcr_pkg::ROW_W) - 1;

   // One request transfer: opcode plus both endpoints (endpoints unused on a step).
   typedef struct packed {
      logic                       opcode;
      logic [lrcr_pkg::COL_W-1:0] start_x;
      logic [lrcr_pkg::ROW_W-1:0] start_y;
      logic [lrcr_pkg::COL_W-1:0] end_x;
      logic [lrcr_pkg::ROW_W-1:0] end_y;
   } line_cmd_type;

   // One response transfer: a column run.
   typedef struct packed {
      logic [lrcr_pkg::COL_W-1:0] column_x;
      logic [lrcr_pkg::ROW_W-1:0] first_y;
      logic [lrcr_pkg::ROW_W-1:0] last_y;
      logic                       pixel;
      logic                       empty;
      logic                       last;
   } column_run_type;

   // Clock and reset. Every DUT input starts at a known value.
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid   = 1'b0;
   logic                       req_ready;
   logic                       req_opcode  = lrcr_pkg::OP_LOAD;
   logic [lrcr_pkg::COL_W-1:0] req_start_x = '0;
   logic [lrcr_pkg::ROW_W-1:0] req_start_y = '0;
   logic [lrcr_pkg::COL_W-1:0] req_end_x   = '0;
   logic [lrcr_pkg::ROW_W-1:0] req_end_y   = '0;

   logic                       rsp_valid;
   logic                       rsp_ready   = 1'b0;
   logic [lrcr_pkg::COL_W-1:0] rsp_column_x;
   logic [lrcr_pkg::ROW_W-1:0] rsp_run_first_y;
   logic [lrcr_pkg::ROW_W-1:0] rsp_run_last_y;
   logic                       rsp_pixel_value;
   logic                       rsp_empty_res;
   logic                       rsp_last;

   logic                       csr_valid      = 1'b0;
   logic                       csr_ready;
   logic                       csr_invert_ink = 1'b0;

   always #4 clock = ~clock;

   line_rasterizer_column_runs_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_column_x    (rsp_column_x),
      .rsp_run_first_y (rsp_run_first_y),
      .rsp_run_last_y  (rsp_run_last_y),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_empty_res   (rsp_empty_res),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_invert_ink  (csr_invert_ink)
   );

   // Stimulus knobs, shared by the test tasks and the response sink.
   int send_idle_pct = 0;     // chance the sender idles before offering a transfer
   int recv_idle_pct = 0;     // chance the sink deasserts ready in a cycle
   int stall_request = 0;     // nonzero: sink holds ready low this many cycles

   int error_count = 0;
   column_run_type expected_runs[$];

   // ------------------------------------------------------------------
   // Walk predictor: mirrors the rasterizer state, updated per accepted
   // request transfer.
   // ------------------------------------------------------------------
   lrcr_pkg::walk_mode_type           walk_state   = lrcr_pkg::MODE_IDLE;
   logic [lrcr_pkg::COL_W-1:0]        col_now      = '0;
   logic [lrcr_pkg::COL_W-1:0]        col_stop     = '0;
   logic [lrcr_pkg::COL_W-1:0]        col_span     = '0;
   logic [lrcr_pkg::ROW_W-1:0]        row_now      = '0;
   logic [lrcr_pkg::ROW_W-1:0]        row_stop     = '0;
   logic signed [lrcr_pkg::ERR_W-1:0] err_acc      = '0;
   logic [lrcr_pkg::DY2_W-1:0]        dy_twice     = '0;
   logic                              heads_down   = 1'b0;
   logic                              ink_inverted = 1'b0;

   // Returns 1 when the command yields a column run.
   function automatic bit rasterize_cmd(input line_cmd_type c, output column_run_type run);
      logic [lrcr_pkg::COL_W-1:0] x0, x1;
      logic [lrcr_pkg::ROW_W-1:0] y0, y1, row;
      int e, span;
      run       = '0;
      run.empty = 1'b1;
      run.last  = 1'b1;
      if (c.opcode == lrcr_pkg::OP_LOAD) begin
         // Swap so the walk always goes toward larger columns.
         if (c.start_x > c.end_x) begin
            x0 = c.end_x;   y0 = c.end_y;   x1 = c.start_x; y1 = c.start_y;
         end else begin
            x0 = c.start_x; y0 = c.start_y; x1 = c.end_x;   y1 = c.end_y;
         end
         col_now    = x0;
         col_stop   = x1;
         row_now    = y0;
         row_stop   = y1;
         err_acc    = '0;
         col_span   = x1 - x0;
         heads_down = (y1 > y0);
         dy_twice   = lrcr_pkg::DY2_W'(heads_down ? 2 * (y1 - y0) : 2 * (y0 - y1));
         walk_state = (x0 == x1) ? lrcr_pkg::MODE_VERT : lrcr_pkg::MODE_SLOPE;
         return 1'b0;
      end
      case (walk_state)
         lrcr_pkg::MODE_VERT: begin
            // Vertical: one run up to the row before the end when the end lies below, else an empty run; ink ignored.
            walk_state = lrcr_pkg::MODE_IDLE;
            if (row_stop > row_now) begin
               run.column_x = col_now;
               run.first_y  = row_now;
               run.last_y   = row_stop - 1'b1;
               run.pixel    = 1'b1;
               run.empty    = 1'b0;
            end
         end
         lrcr_pkg::MODE_SLOPE: begin
            // Error is scaled by 2*dx: add 2*dy per column, take 2*dx per row.
            row  = row_now;
            e    = int'(err_acc) + int'(dy_twice);
            span = int'(col_span);
            while (e >= span) begin
               row = heads_down ? row + 1'b1 : row - 1'b1;
               e  -= 2 * span;
            end
            run.column_x = col_now;
            run.first_y  = row_now;
            run.last_y   = row;
            run.pixel    = ~ink_inverted;
            run.empty    = 1'b0;
            run.last     = (int'(col_now) + 1 >= int'(col_stop));
            err_acc      = lrcr_pkg::ERR_W'(e);
            row_now      = row;
            col_now      = col_now + 1'b1;
            if (run.last)
               walk_state = lrcr_pkg::MODE_IDLE;
         end
         default: walk_state = lrcr_pkg::MODE_IDLE;
      endcase
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Response sink: random ready, plus long hold-offs on request.
   // ------------------------------------------------------------------
   initial begin : response_sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_request > 0) begin
            stall_left    = stall_request;
            stall_request = 0;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // ------------------------------------------------------------------
   // Response checker: every response transfer against the oldest
   // expected run, field by field.
   // ------------------------------------------------------------------
   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      column_run_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_runs.size() == 0) begin
            $display("%0t: unexpected run, expected none, actual x=%0d y=%0d..%0d v=%0d e=%0d l=%0d",
                     $time, rsp_column_x, rsp_run_first_y, rsp_run_last_y,
                     rsp_pixel_value, rsp_empty_res, rsp_last);
            error_count++;
         end else begin
            want = expected_runs.pop_front();
            compare_field("column_x",    int'(want.column_x), int'(rsp_column_x));
            compare_field("run_first_y", int'(want.first_y),  int'(rsp_run_first_y));
            compare_field("run_last_y",  int'(want.last_y),   int'(rsp_run_last_y));
            compare_field("pixel_value", int'(want.pixel),    int'(rsp_pixel_value));
            compare_field("empty_res",   int'(want.empty),    int'(rsp_empty_res));
            compare_field("last",        int'(want.last),     int'(rsp_last));
         end
      end
   end

   // ------------------------------------------------------------------
   // Request side.
   // ------------------------------------------------------------------

   // Offer one request transfer, hold it until taken, then predict its run.
   // Valid is left high; a pause, or an idle in the next call, lowers it.
   task automatic send_cmd(input line_cmd_type c);
      column_run_type run;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= c.opcode;
      req_start_x <= c.start_x;
      req_start_y <= c.start_y;
      req_end_x   <= c.end_x;
      req_end_y   <= c.end_y;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (rasterize_cmd(c, run))
         expected_runs.push_back(run);
   endtask

   function automatic line_cmd_type random_cmd(input logic op);
      line_cmd_type c;
      c.opcode  = op;
      c.start_x = lrcr_pkg::COL_W'($urandom);
      c.start_y = lrcr_pkg::ROW_W'($urandom);
      c.end_x   = lrcr_pkg::COL_W'($urandom);
      c.end_y   = lrcr_pkg::ROW_W'($urandom);
      return c;
   endfunction

   task automatic send_line(input int sx, input int sy, input int ex, input int ey);
      line_cmd_type c;
      c.opcode  = lrcr_pkg::OP_LOAD;
      c.start_x = lrcr_pkg::COL_W'(sx);
      c.start_y = lrcr_pkg::ROW_W'(sy);
      c.end_x   = lrcr_pkg::COL_W'(ex);
      c.end_y   = lrcr_pkg::ROW_W'(ey);
      send_cmd(c);
   endtask

   task automatic send_steps(input int n);
      repeat (n) send_cmd(random_cmd(lrcr_pkg::OP_STEP));
   endtask

   // Stop offering and wait until every expected run has been seen.
   task automatic pause_sender();
      req_valid <= 1'b0;
      while (expected_runs.size() != 0) @(posedge clock);
   endtask

   // A load gives no run, so wait after the pause for it to finish before a CSR write.
   task automatic settle_idle();
      pause_sender();
      repeat (4) @(posedge clock);
   endtask

   task automatic write_ink(input logic ink);
      csr_valid      <= 1'b1;
      csr_invert_ink <= ink;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      ink_inverted = ink;
      csr_valid <= 1'b0;
   endtask

   // A well-formed line: load plus its runs, sometimes cut short or overrun.
   task automatic send_random_line(inout int sent);
      int sx, sy, ex, ey, runs, steps, pick;
      sx = $urandom_range(MAX_X);
      sy = $urandom_range(MAX_Y);
      if ($urandom_range(1))
         ex = $urandom_range(MAX_X);
      else
         ex = sx + $urandom_range(16) - 8;
      if ($urandom_range(9) == 0)
         ex = sx;
      if (ex < 0)     ex = 0;
      if (ex > MAX_X) ex = MAX_X;
      case ($urandom_range(3))
         0:       ey = sy;
         1:       ey = sy + $urandom_range(16) - 8;
         default: ey = $urandom_range(MAX_Y);
      endcase
      if (ey < 0)     ey = 0;
      if (ey > MAX_Y) ey = MAX_Y;
      send_line(sx, sy, ex, ey);
      sent++;
      runs  = (sx == ex) ? 1 : ((ex > sx) ? ex - sx : sx - ex);
      steps = runs;
      pick  = $urandom_range(99);
      if (pick < 15)
         steps = $urandom_range(runs - 1);        // cut off by the next load
      else if (pick < 30)
         steps = runs + $urandom_range(3, 1);     // steps past the end
      send_steps(steps);
      sent += steps;
   endtask

   task automatic run_random_phase(input int n_items, input int send_pct,
                                   input int recv_pct, input logic ink);
      int sent;
      sent = 0;
      settle_idle();
      write_ink(ink);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      while (sent < n_items) begin
         if ($urandom_range(99) < 80) begin
            send_random_line(sent);
         end else begin
            // Noise: any opcode, any endpoints.
            send_cmd(random_cmd(1'($urandom_range(1))));
            sent++;
         end
         if ($urandom_range(99) < 3)
            pause_sender();
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Corners: idle step, vertical up/down/point, full-height vertical,
   // steepest line with swap, horizontal, reload in mid-walk.
   task automatic test_directed_cases();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_ink(1'b0);
      send_steps(1);
      send_line(5, 10, 5, 20);     send_steps(1);
      send_line(5, 200, 5, 100);   send_steps(1);
      send_line(7, 7, 7, 7);       send_steps(2);
      send_line(0, 0, 0, MAX_Y);   send_steps(1);
      send_line(MAX_X, MAX_Y, MAX_X - 1, 0);
      send_steps(2);
      send_line(0, 0, 3, 0);       send_steps(3);
      send_line(10, 50, 14, 40);   send_steps(2);
      send_line(0, MAX_Y, 2, MAX_Y);
      send_steps(2);
   endtask

   // Inverted ink on a sloped line; vertical lines keep value 1.
   task automatic test_ink_register();
      settle_idle();
      write_ink(1'b1);
      send_line(20, 30, 23, 40);   send_steps(3);
      send_line(9, 0, 9, 4);       send_steps(1);
      settle_idle();
      write_ink(1'b0);
   endtask

   // Sink holds off long enough for the run register and the walk to fill,
   // so the request side backs up while the sender keeps offering.
   task automatic test_backpressure();
      settle_idle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_request = 300;
      send_line(0, 0, 60, 100);
      send_steps(60);
      pause_sender();
   endtask

   task automatic test_random_slow_receiver();
      run_random_phase(540, 18, 80, 1'b1);
   endtask

   task automatic test_random_slow_sender();
      run_random_phase(540, 80, 18, 1'b0);
   endtask

   task automatic test_random_full_rate();
      run_random_phase(540, 0, 0, 1'b1);
   endtask

   initial begin : test_sequence
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_ink_register();
      test_backpressure();
      test_random_slow_receiver();
      test_random_slow_sender();
      test_random_full_rate();
      pause_sender();
      // Wait out any steep step still walking; catch anything stray.
      repeat (300) @(posedge clock);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Hard limit, far beyond the slowest legal run.
   initial begin : watchdog
      #(30_000_000);
      $display("Some tests failed");
      $finish;
   end

endmodule
